>>> hw/rtl/eiuhf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eiuhf_pkg;

    localparam int unsigned DEF_MAX_FRAME_BYTES = 65535;
    localparam int unsigned DEF_COUNTER_BITS    = 32;
    localparam int unsigned QUEUE_DEPTH         = 4;

    localparam int unsigned LEN_W      = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 216;
    localparam int unsigned M_USER_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_IP_CHECK = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_ADDR     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_UDP_PORT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_UDP_PORT  = CFG_IDX_W'(3);

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [7:0]  IHL_MASK       = 8'h0F;
    localparam int unsigned ETH_HDR_BYTES  = 14;
    localparam int unsigned IP_MIN_BYTES   = 20;
    localparam int unsigned UDP_HDR_BYTES  = 8;

    typedef enum logic [2:0] {
        CLS_PARSE_FAIL = 3'd0,
        CLS_NON_IPV4   = 3'd1,
        CLS_NON_UDP    = 3'd2,
        CLS_MISMATCH   = 3'd3,
        CLS_MATCH      = 3'd4
    } t_frame_class;

    typedef struct packed {
        logic        remote_ip_check;
        logic [31:0] remote_addr;
        logic [15:0] remote_udp_port;
        logic [15:0] local_udp_port;
    } t_filter_cfg;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [15:0]      kind;
        logic [5:0]       ihl;
        logic [7:0]       proto;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
    } t_frame_desc;

endpackage
`default_nettype wire

>>> hw/rtl/eiuhf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module eiuhf_front #(
    parameter int unsigned MAX_FRAME_BYTES = eiuhf_pkg::DEF_MAX_FRAME_BYTES
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [7:0]                    i_byte,
    input  wire                           i_last,
    input  wire                           i_q_full,
    output logic                          o_push,
    output eiuhf_pkg::t_frame_desc        o_desc
);
    import eiuhf_pkg::*;

    logic [LEN_W-1:0] r_pos,   n_pos;
    logic [15:0]      r_kind,  n_kind;
    logic [5:0]       r_ihl,   n_ihl;
    logic [7:0]       r_proto, n_proto;
    logic [31:0]      r_src,   n_src;
    logic [31:0]      r_dst,   n_dst;
    logic [15:0]      r_sport, n_sport;
    logic [15:0]      r_dport, n_dport;

    logic             accept;
    logic             take;
    logic [LEN_W:0]   port_base;
    logic [LEN_W:0]   port_off;
    logic             in_ports;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign take    = r_pos < LEN_W'(MAX_FRAME_BYTES);

    // UDP header sits right behind the IPv4 header, whose length is known from byte 14 on
    assign port_base = (LEN_W+1)'(ETH_HDR_BYTES) + (LEN_W+1)'(r_ihl);
    assign port_off  = {1'b0, r_pos} - port_base;
    assign in_ports  = (r_ihl >= 6'(IP_MIN_BYTES)) && ({1'b0, r_pos} >= port_base)
                       && (port_off < (LEN_W+1)'(4));

    always_comb begin
        n_pos   = r_pos;
        n_kind  = r_kind;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;
        if (take) begin
            n_pos = r_pos + LEN_W'(1);
            if (r_pos == LEN_W'(12) || r_pos == LEN_W'(13)) begin
                n_kind = {r_kind[7:0], i_byte};
            end else if (r_pos == LEN_W'(14)) begin
                n_ihl = {i_byte[3:0] & IHL_MASK[3:0], 2'b00};
            end else if (r_pos == LEN_W'(23)) begin
                n_proto = i_byte;
            end else if (r_pos >= LEN_W'(26) && r_pos <= LEN_W'(29)) begin
                n_src = {r_src[23:0], i_byte};
            end else if (r_pos >= LEN_W'(30) && r_pos <= LEN_W'(33)) begin
                n_dst = {r_dst[23:0], i_byte};
            end
            if (in_ports) begin
                if (port_off[1] == 1'b0) begin
                    n_sport = {r_sport[7:0], i_byte};
                end else begin
                    n_dport = {r_dport[7:0], i_byte};
                end
            end
        end
    end

    assign o_push          = accept && i_last;
    assign o_desc.len      = n_pos;
    assign o_desc.kind     = n_kind;
    assign o_desc.ihl      = n_ihl;
    assign o_desc.proto    = n_proto;
    assign o_desc.src_addr = n_src;
    assign o_desc.dst_addr = n_dst;
    assign o_desc.src_port = n_sport;
    assign o_desc.dst_port = n_dport;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            // start every frame from a clean slate
            r_pos   <= '0;
            r_kind  <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/eiuhf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module eiuhf_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/eiuhf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module eiuhf_back #(
    parameter int unsigned COUNTER_BITS = eiuhf_pkg::DEF_COUNTER_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  eiuhf_pkg::t_filter_cfg                i_cfg,
    input  wire                                   i_q_valid,
    input  eiuhf_pkg::t_frame_desc                i_desc,
    output logic                                  o_q_pop,
    input  wire                                   i_m_tready,
    output logic                                  o_m_tvalid,
    output logic [eiuhf_pkg::M_DATA_W-1:0]        o_m_tdata,
    output logic [eiuhf_pkg::M_USER_W-1:0]        o_m_tuser
);
    import eiuhf_pkg::*;

    localparam int unsigned XW = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;

    logic [COUNTER_BITS-1:0] r_total;
    logic [COUNTER_BITS-1:0] r_class_cnt [5];
    logic [COUNTER_BITS-1:0] n_total;
    logic [COUNTER_BITS-1:0] n_class_cnt;
    logic [XW-1:0]           total_ext;
    logic [XW-1:0]           class_ext;

    logic                    r_valid;
    logic [M_DATA_W-1:0]     r_data;
    logic [M_USER_W-1:0]     r_user;
    logic [M_DATA_W-1:0]     n_data;

    t_frame_class            cls;
    logic [LEN_W:0]          ip_end;
    logic [LEN_W:0]          udp_end;
    logic [LEN_W:0]          len_x;
    logic                    ip_ok;
    logic                    udp_ok;
    logic                    match;
    logic [15:0]             payload;

    function automatic logic one_way(input t_filter_cfg cfg, input logic [31:0] addr,
                                     input logic [15:0] rport, input logic [15:0] lport);
        logic a;
        logic r;
        logic l;
        a = !cfg.remote_ip_check || (addr == cfg.remote_addr);
        r = (cfg.remote_udp_port == 16'd0) || (rport == cfg.remote_udp_port);
        l = (cfg.local_udp_port == 16'd0) || (lport == cfg.local_udp_port);
        return a && r && l;
    endfunction

    assign len_x   = {1'b0, i_desc.len};
    assign ip_end  = (LEN_W+1)'(ETH_HDR_BYTES) + (LEN_W+1)'(i_desc.ihl);
    assign udp_end = ip_end + (LEN_W+1)'(UDP_HDR_BYTES);
    assign match   = one_way(i_cfg, i_desc.src_addr, i_desc.src_port, i_desc.dst_port)
                  || one_way(i_cfg, i_desc.dst_addr, i_desc.dst_port, i_desc.src_port);

    always_comb begin
        if (len_x < (LEN_W+1)'(ETH_HDR_BYTES)) begin
            cls = CLS_PARSE_FAIL;
        end else if (i_desc.kind != ETHERTYPE_IPV4) begin
            cls = CLS_NON_IPV4;
        end else if (len_x < (LEN_W+1)'(ETH_HDR_BYTES + IP_MIN_BYTES)) begin
            cls = CLS_PARSE_FAIL;
        end else if (i_desc.ihl < 6'(IP_MIN_BYTES) || len_x < ip_end) begin
            cls = CLS_PARSE_FAIL;
        end else if (i_desc.proto != PROTO_UDP) begin
            cls = CLS_NON_UDP;
        end else if (len_x < udp_end) begin
            cls = CLS_PARSE_FAIL;
        end else if (match) begin
            cls = CLS_MATCH;
        end else begin
            cls = CLS_MISMATCH;
        end
    end

    assign ip_ok   = (cls == CLS_NON_UDP) || (cls == CLS_MISMATCH) || (cls == CLS_MATCH);
    assign udp_ok  = (cls == CLS_MISMATCH) || (cls == CLS_MATCH);
    assign payload = 16'(len_x - udp_end);

    assign n_total     = (r_total == '1) ? r_total : r_total + COUNTER_BITS'(1);
    assign n_class_cnt = (r_class_cnt[cls] == '1) ? r_class_cnt[cls]
                                                  : r_class_cnt[cls] + COUNTER_BITS'(1);
    assign total_ext   = XW'(n_total);
    assign class_ext   = XW'(n_class_cnt);

    always_comb begin
        n_data          = '0;
        n_data[15:0]    = (len_x >= (LEN_W+1)'(ETH_HDR_BYTES)) ? i_desc.kind : 16'd0;
        n_data[23:16]   = ip_ok  ? i_desc.proto    : 8'd0;
        n_data[55:24]   = ip_ok  ? i_desc.src_addr : 32'd0;
        n_data[87:56]   = ip_ok  ? i_desc.dst_addr : 32'd0;
        n_data[103:88]  = udp_ok ? i_desc.src_port : 16'd0;
        n_data[119:104] = udp_ok ? i_desc.dst_port : 16'd0;
        n_data[135:120] = udp_ok ? payload         : 16'd0;
        n_data[151:136] = 16'(i_desc.len);
        n_data[183:152] = total_ext[31:0];
        n_data[215:184] = class_ext[31:0];
    end

    // take the next descriptor whenever the output register is free or draining
    assign o_q_pop = i_q_valid && (!r_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_total <= '0;
            for (int i = 0; i < 5; i++) begin
                r_class_cnt[i] <= '0;
            end
        end else begin
            if (o_q_pop) begin
                r_valid          <= 1'b1;
                r_total          <= n_total;
                r_class_cnt[cls] <= n_class_cnt;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_data <= n_data;
            r_user <= cls;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;

endmodule
`default_nettype wire

>>> hw/rtl/eth_ipv4_udp_header_filter.sv
// Ethernet / IPv4 / UDP header filter.
// Slave stream: one frame byte per transaction in s_axis_tdata, starting at the
// destination MAC; s_axis_tlast marks the final captured byte. Bytes are taken
// every cycle while the descriptor queue has room.
// Master stream: one classified result per frame. m_axis_tuser carries the class
// (parse failure, non-IPv4, non-UDP, filter mismatch, matched); m_axis_tdata the
// latched header fields, UDP payload length, frame length and saturating counters.
// Config channel: cfg_index selects remote_ip_check, remote_addr, remote_udp_port
// or local_udp_port; other indexes are ignored. Write only while the block is idle.
// Each descriptor is queued, then registered in the back end's output register.
// Throughput: one byte per cycle while the queue has room; one result per cycle
// for one-byte frames while results are taken, set by the single output register.
// A four-entry descriptor queue separates the byte parser from the classifier, so
// a stalled master side costs nothing until five results are waiting (four queued,
// one held at the output); then s_axis_tready drops and the output holds its
// transaction until taken.
// Reset clears the per-frame state, all counters, the filters and the queue.
`timescale 1ns / 1ps
`default_nettype none
module eth_ipv4_udp_header_filter #(
    parameter int unsigned MAX_FRAME_BYTES = eiuhf_pkg::DEF_MAX_FRAME_BYTES,
    parameter int unsigned COUNTER_BITS    = eiuhf_pkg::DEF_COUNTER_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire  [eiuhf_pkg::S_DATA_W-1:0]      i_s_axis_tdata,  // [7:0] data_byte
    input  wire                                 i_s_axis_tlast,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // [15:0] ether_kind, [23:16] ip_proto, [55:24] src_addr, [87:56] dst_addr,
    // [103:88] src_port, [119:104] dst_port, [135:120] payload_len,
    // [151:136] frame_len, [183:152] total_frames, [215:184] class_frames
    output logic [eiuhf_pkg::M_DATA_W-1:0]      o_m_axis_tdata,
    output logic [eiuhf_pkg::M_USER_W-1:0]      o_m_axis_tuser,  // [2:0] frame_class
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [eiuhf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [eiuhf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import eiuhf_pkg::*;

    t_filter_cfg r_cfg;
    t_frame_desc push_desc;
    t_frame_desc head_desc;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REMOTE_IP_CHECK: r_cfg.remote_ip_check <= i_cfg_data[0];
                CFG_REMOTE_ADDR:     r_cfg.remote_addr     <= i_cfg_data;
                CFG_REMOTE_UDP_PORT: r_cfg.remote_udp_port <= i_cfg_data[15:0];
                CFG_LOCAL_UDP_PORT:  r_cfg.local_udp_port  <= i_cfg_data[15:0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    eiuhf_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_desc   (push_desc)
    );

    eiuhf_queue #(
        .WIDTH ($bits(t_frame_desc)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (head_desc)
    );

    eiuhf_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_desc     (head_desc),
        .o_q_pop    (q_pop),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

>>> hw/rtl/eiuhf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module eiuhf_checker (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               o_m_axis_tvalid,
    input wire                               i_m_axis_tready,
    input wire [eiuhf_pkg::M_DATA_W-1:0]     o_m_axis_tdata,
    input wire [eiuhf_pkg::M_USER_W-1:0]     o_m_axis_tuser
);
    import eiuhf_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser <= M_USER_W'(CLS_MATCH))
        else $error("frame class out of range");

    a_udp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser < M_USER_W'(CLS_MISMATCH)) |->
            o_m_axis_tdata[135:88] == '0)
        else $error("UDP fields set on a non-UDP result");

    a_ip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser < M_USER_W'(CLS_NON_UDP)) |->
            o_m_axis_tdata[87:16] == '0)
        else $error("IPv4 fields set on a non-IPv4 result");

endmodule

bind eth_ipv4_udp_header_filter eiuhf_checker u_eiuhf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire
